### rtl/core/bte_pkg.sv
package bte_pkg;

  // Kind of output run the back part expands
  typedef enum logic [2:0] {
    CmdEnd   = 3'd0,  // end marker only, no character
    CmdPlain = 3'd1,  // one literal byte
    CmdEsc2  = 3'd2,  // backslash + one byte
    CmdHex4  = 3'd3,  // \uXXXX
    CmdHex8  = 3'd4,  // \UXXXXXXXX
    CmdRaw4  = 3'd5   // four raw UTF-8 bytes, lead first
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] data;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic c_style;
    logic zero_term;
  } cfg_t;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgEscapeStyle   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgZeroTerminates = 1'd1;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChUpperU    = 8'h55;
  localparam logic [7:0] ChDigit0    = 8'h30;
  localparam logic [7:0] HexAlphaOff = 8'h37;  // 'A' - 10

  localparam int unsigned MaxResults = 10;
  localparam int unsigned IdxW       = 4;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (ChDigit0 + {4'h0, d}) : (HexAlphaOff + {4'h0, d});
  endfunction

endpackage

### rtl/core/backslash_text_escaper_top.sv
// Channel | Dir | Handshake                       | Payload
// --------+-----+---------------------------------+-------------------------------
// in      | in  | in_valid_i / in_stall_o         | in_byte_i, in_last_i
// out     | out | out_valid_o / out_stall_i       | out_char_o, has_char_o, out_last_o
// cfg     | in  | cfg_valid_i / cfg_ready_o (=1)  | cfg_index_i, cfg_wdata_i
//
// One input byte is taken per cycle while the command queue has room; the back
// end emits one character per cycle while the queue is not empty and
// out_stall_i is low, so a byte yields 0 to 10 characters (none for bytes that
// complete nothing, 10 for \UXXXXXXXX). Commands pass through the queue to the
// output register. Async active-low reset clears decoder state, queue and output
// valid, and sets JSON style, no zero termination. in_stall_o is queue full;
// out_stall_i holds the output register and the expander.
module backslash_text_escaper_top
  import bte_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  // escaped output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_char_o,
  output logic               has_char_o,
  output logic               out_last_o,
  // register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic               cfg_wdata_i
);

  cfg_t cfg_q;
  logic q_push, q_pop, q_empty, q_full;
  cmd_t push_cmd, head_cmd;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgEscapeStyle:    cfg_q.c_style   <= cfg_wdata_i;
        CfgZeroTerminates: cfg_q.zero_term <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front: UTF-8 decode and classification into commands, at most one per byte
  bte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (q_push),
    .cmd_o      (push_cmd)
  );

  // decouples byte intake from character expansion
  bte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_cmd),
    .pop_i   (q_pop),
    .data_o  (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: expands each command into output characters
  bte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .has_char_o  (has_char_o),
    .out_last_o  (out_last_o)
  );

endmodule

### rtl/core/bte_front.sv
module bte_front
  import bte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam logic [20:0] MinLen2  = 21'h000080;
  localparam logic [20:0] MinLen3  = 21'h000800;
  localparam logic [20:0] MinLen4  = 21'h010000;
  localparam logic [20:0] SurLo    = 21'h00D800;
  localparam logic [20:0] SurHi    = 21'h00DFFF;
  localparam logic [20:0] CpMax    = 21'h10FFFF;
  localparam logic [20:0] BmpMax   = 21'h00FFFF;

  logic        term_q, term_d;
  logic [1:0]  exp_q, exp_d;
  logic [1:0]  held_q, held_d;
  logic [20:0] acc_q, acc_d;
  logic [7:0]  held_bytes_q [3];

  logic        accept;
  logic        is_cont;
  logic [20:0] acc_next;
  logic [20:0] min_cp;
  logic        cp_ok;
  logic        wr_held;
  logic [1:0]  wr_idx;
  logic        emit;
  cmd_kind_e   kind;
  logic [31:0] data;
  logic [7:0]  second;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_cont    = (in_byte_i[7:6] == 2'b10);
  assign acc_next   = {acc_q[14:0], in_byte_i[5:0]};

  always_comb begin
    unique case (held_q)
      2'd1:    min_cp = MinLen2;
      2'd2:    min_cp = MinLen3;
      default: min_cp = MinLen4;
    endcase
    cp_ok = (acc_next >= min_cp) && !((acc_next >= SurLo) && (acc_next <= SurHi)) &&
            (acc_next <= CpMax);
  end

  always_comb begin
    unique case (in_byte_i)
      8'h09:   second = 8'h74;  // t
      8'h0A:   second = 8'h6E;  // n
      8'h0D:   second = 8'h72;  // r
      8'h0C:   second = 8'h66;  // f
      8'h08:   second = 8'h62;  // b
      8'h0B:   second = cfg_i.c_style ? 8'h76 : 8'h00;  // v, C only
      default: second = 8'h00;
    endcase
  end

  always_comb begin
    term_d  = term_q;
    exp_d   = exp_q;
    held_d  = held_q;
    acc_d   = acc_q;
    wr_held = 1'b0;
    wr_idx  = held_q;
    emit    = 1'b0;
    kind    = CmdPlain;
    data    = '0;

    if (!term_q) begin
      if ((exp_q != 2'd0) && is_cont) begin
        acc_d = acc_next;
        exp_d = exp_q - 2'd1;
        if (exp_q == 2'd1) begin
          // sequence complete
          exp_d  = '0;
          held_d = '0;
          acc_d  = '0;
          if (cp_ok) begin
            emit = 1'b1;
            if (acc_next <= BmpMax) begin
              kind = CmdHex4;
              data = {16'h0, acc_next[15:0]};
            end else if (cfg_i.c_style) begin
              kind = CmdHex8;
              data = {11'h0, acc_next};
            end else begin
              kind = CmdRaw4;
              data = {held_bytes_q[0], held_bytes_q[1], held_bytes_q[2], in_byte_i};
            end
          end
        end else if (held_q != 2'd3) begin
          wr_held = 1'b1;
          held_d  = held_q + 2'd1;
        end
      end else begin
        // fresh byte; any pending sequence is dropped
        exp_d  = '0;
        held_d = '0;
        acc_d  = '0;
        if (cfg_i.zero_term && (in_byte_i == 8'h00)) begin
          term_d = 1'b1;
        end else if (!in_byte_i[7]) begin
          emit = 1'b1;
          if (in_byte_i < 8'h20) begin
            if (second != 8'h00) begin
              kind = CmdEsc2;
              data = {24'h0, second};
            end else begin
              kind = CmdHex4;
              data = {24'h0, in_byte_i};
            end
          end else if ((in_byte_i == ChBackslash) || (in_byte_i == 8'h22) ||
                       (cfg_i.c_style && (in_byte_i == 8'h27))) begin
            kind = CmdEsc2;
            data = {24'h0, in_byte_i};
          end else begin
            kind = CmdPlain;
            data = {24'h0, in_byte_i};
          end
        end else if (in_byte_i[7:5] == 3'b110) begin
          exp_d = 2'd1; held_d = 2'd1; wr_held = 1'b1; wr_idx = 2'd0;
          acc_d = {16'h0, in_byte_i[4:0]};
        end else if (in_byte_i[7:4] == 4'b1110) begin
          exp_d = 2'd2; held_d = 2'd1; wr_held = 1'b1; wr_idx = 2'd0;
          acc_d = {17'h0, in_byte_i[3:0]};
        end else if (in_byte_i[7:3] == 5'b11110) begin
          exp_d = 2'd3; held_d = 2'd1; wr_held = 1'b1; wr_idx = 2'd0;
          acc_d = {18'h0, in_byte_i[2:0]};
        end
      end
    end

    if (in_last_i) begin
      exp_d  = '0;
      held_d = '0;
      acc_d  = '0;
      term_d = 1'b0;
      if (!emit) begin
        emit = 1'b1;
        kind = CmdEnd;
        data = '0;
      end
    end
  end

  assign push_o     = accept && emit;
  assign cmd_o.kind = kind;
  assign cmd_o.data = data;
  assign cmd_o.last = in_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= 1'b0;
      exp_q  <= '0;
      held_q <= '0;
      acc_q  <= '0;
    end else if (accept) begin
      term_q <= term_d;
      exp_q  <= exp_d;
      held_q <= held_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_held) begin
      held_bytes_q[wr_idx] <= in_byte_i;
    end
  end

endmodule

### rtl/core/bte_queue.sv
module bte_queue
  import bte_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/bte_back.sv
module bte_back
  import bte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       has_char_o,
  output logic       out_last_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q;
  logic [7:0]      char_q;
  logic            has_q;
  logic            last_q;

  logic            load;
  logic            final_char;
  logic [7:0]      ch;
  logic            has;
  logic [IdxW-1:0] nib_sel;
  logic [1:0]      byte_sel;
  logic [3:0]      nib;
  logic [7:0]      raw_byte;

  assign load     = !empty_i && (!out_valid_q || !out_stall_i);
  assign nib_sel  = ((cmd_i.kind == CmdHex8) ? IdxW'(9) : IdxW'(5)) - idx_q;
  assign byte_sel = 2'd3 - idx_q[1:0];
  assign nib      = cmd_i.data[{nib_sel[2:0], 2'b00} +: 4];
  assign raw_byte = cmd_i.data[{byte_sel, 3'b000} +: 8];

  always_comb begin
    ch         = 8'h00;
    has        = 1'b1;
    final_char = 1'b1;
    unique case (cmd_i.kind)
      CmdEnd: begin
        has = 1'b0;
      end
      CmdPlain: begin
        ch = cmd_i.data[7:0];
      end
      CmdEsc2: begin
        ch         = (idx_q == '0) ? ChBackslash : cmd_i.data[7:0];
        final_char = (idx_q == IdxW'(1));
      end
      CmdHex4, CmdHex8: begin
        if (idx_q == '0) begin
          ch = ChBackslash;
        end else if (idx_q == IdxW'(1)) begin
          ch = (cmd_i.kind == CmdHex8) ? ChUpperU : ChLowerU;
        end else begin
          ch = hex_char(nib);
        end
        final_char = (cmd_i.kind == CmdHex8) ? (idx_q == IdxW'(9)) : (idx_q == IdxW'(5));
      end
      CmdRaw4: begin
        ch         = raw_byte;
        final_char = (idx_q == IdxW'(3));
      end
      default: begin
        has = 1'b0;
      end
    endcase
  end

  assign pop_o = load && final_char;
  assign idx_d = load ? (final_char ? '0 : idx_q + 1'b1) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= ch;
      has_q  <= has;
      last_q <= cmd_i.last && final_char;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = char_q;
  assign has_char_o  = has_q;
  assign out_last_o  = last_q;

  // run position never passes the longest escape
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < IdxW'(MaxResults))
    else $error("run index out of range");

  // a run that is partly emitted keeps its entry at the queue head
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> !empty_i)
    else $error("queue emptied mid-run");

  // an end-marker-only item is always the last of its string
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !has_q) |-> last_q)
    else $error("end marker without last");

endmodule
